// ===== hdl/fpfa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpfa_pkg
// Shared types and codes for the ring arbiter: sequencer states, event
// codes and the command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package fpfa_pkg;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [4:0] DONE_SAT = 5'd31;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } fpfa_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic check;
    } fpfa_cmd_t;

    typedef struct packed {
        logic out_stall;
    } fpfa_status_t;

endpackage
`default_nettype wire

// ===== hdl/fpfa_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module fpfa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== hdl/fpfa_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpfa_ctrl
// Sequencer: capture a transaction, apply the event, read the queue head,
// then check the head and load the result register.
// ---------------------------------------------------------------------------
module fpfa_ctrl
    import fpfa_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire fpfa_status_t status,
    output fpfa_cmd_t         cmd
);

    fpfa_state_t state_reg;
    fpfa_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // hold until the result register can take the new result
                if (!status.out_stall)
                begin
                    cmd.check  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/fpfa_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fpfa_datapath
// Resource bitmap, wait queue with its pointers, completion counter, ring
// size register and result register.
// ---------------------------------------------------------------------------
module fpfa_datapath
    import fpfa_pkg::*;
#(
    parameter int MAX_REQUESTERS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_wdata,
    input  wire logic         func,
    input  wire logic [4:0]   requester_id,
    input  wire fpfa_cmd_t    cmd,
    output fpfa_status_t      status,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              grant_valid,
    output logic [4:0]        grant_id,
    output logic              release_error,
    output logic              queue_overflow,
    output logic              bad_id,
    output logic              all_satisfied
);

    localparam int IW   = $clog2(MAX_REQUESTERS);
    localparam int CNTW = $clog2(MAX_REQUESTERS + 1);

    logic [4:0]                num_req_reg;
    logic                      func_reg;
    logic [4:0]                id_reg;
    logic [MAX_REQUESTERS-1:0] free_reg;
    logic [IW-1:0]             head_reg;
    logic [IW-1:0]             tail_reg;
    logic [CNTW-1:0]           count_reg;
    logic [4:0]                done_reg;
    logic                      bad_reg;
    logic                      ovf_reg;
    logic                      rel_err_reg;

    logic                      out_valid_reg;
    logic                      grant_valid_reg;
    logic [4:0]                grant_id_reg;
    logic                      release_error_reg;
    logic                      queue_overflow_reg;
    logic                      bad_id_reg;
    logic                      all_sat_reg;

    logic [4:0]                ring_n;
    logic                      id_bad;
    logic [IW-1:0]             k;
    logic [MAX_REQUESTERS-1:0] rel_mask;
    logic [MAX_REQUESTERS-1:0] head_mask;
    logic [IW-1:0]             head_entry;
    logic                      ram_we;
    logic                      head_grant;
    logic [IW:0]               head_id_plus;

    function automatic logic [MAX_REQUESTERS-1:0] pair_mask(
        input logic [IW-1:0] idx,
        input logic [4:0]    n
    );
        logic [MAX_REQUESTERS-1:0] m;
        logic [IW-1:0]             other;
        m     = '0;
        other = (idx == '0) ? IW'(n - 5'd1) : idx - IW'(1);
        m[idx]   = 1'b1;
        m[other] = 1'b1;
        return m;
    endfunction

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == IW'(MAX_REQUESTERS - 1)) ? '0 : p + IW'(1);
    endfunction

    // clamp the ring size into the supported range
    always_comb
    begin
        priority if (num_req_reg < 5'd2)
        begin
            ring_n = 5'd2;
        end
        else if (32'(num_req_reg) > MAX_REQUESTERS)
        begin
            ring_n = 5'(MAX_REQUESTERS);
        end
        else
        begin
            ring_n = num_req_reg;
        end
    end

    assign id_bad     = (id_reg == 5'd0) || (id_reg > ring_n);
    assign k          = IW'(id_reg - 5'd1);
    assign rel_mask   = pair_mask(k, ring_n);
    assign head_mask  = pair_mask(head_entry, ring_n);
    assign ram_we     = cmd.exec && !id_bad && (func_reg == FUNC_REQUEST)
                        && (count_reg != CNTW'(MAX_REQUESTERS));
    assign head_grant = (count_reg != '0) && ((free_reg & head_mask) == head_mask);
    assign head_id_plus = {1'b0, head_entry} + (IW+1)'(1);

    fpfa_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_REQUESTERS)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (k),
        .re    (cmd.read),
        .raddr (head_reg),
        .rdata (head_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_req_reg <= 5'd4;
        end
        else if (cfg_we)
        begin
            num_req_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            id_reg   <= requester_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= '1;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
            bad_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            rel_err_reg <= 1'b0;
        end
        else if (cmd.exec)
        begin
            bad_reg     <= id_bad;
            ovf_reg     <= 1'b0;
            rel_err_reg <= 1'b0;
            if (!id_bad)
            begin
                if (func_reg == FUNC_REQUEST)
                begin
                    if (ram_we)
                    begin
                        tail_reg  <= wrap_inc(tail_reg);
                        count_reg <= count_reg + CNTW'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (done_reg < DONE_SAT)
                    begin
                        done_reg <= done_reg + 5'd1;
                    end
                    if ((free_reg & rel_mask) == '0)
                    begin
                        free_reg <= free_reg | rel_mask;
                    end
                    else
                    begin
                        rel_err_reg <= 1'b1;
                    end
                end
            end
        end
        else if (cmd.check && head_grant)
        begin
            free_reg  <= free_reg & ~head_mask;
            head_reg  <= wrap_inc(head_reg);
            count_reg <= count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            grant_valid_reg    <= head_grant;
            grant_id_reg       <= head_grant ? 5'(head_id_plus) : 5'd0;
            release_error_reg  <= rel_err_reg;
            queue_overflow_reg <= ovf_reg;
            bad_id_reg         <= bad_reg;
            all_sat_reg        <= (done_reg >= ring_n);
        end
    end

    assign status.out_stall = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign grant_valid    = grant_valid_reg;
    assign grant_id       = grant_id_reg;
    assign release_error  = release_error_reg;
    assign queue_overflow = queue_overflow_reg;
    assign bad_id         = bad_id_reg;
    assign all_satisfied  = all_sat_reg;

endmodule
`default_nettype wire

// ===== hdl/fork_pair_fifo_arbiter.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fork_pair_fifo_arbiter
// Ring arbiter: requesters share the resources on either side of them, wait
// in a FIFO and are granted strictly from its head.
// ---------------------------------------------------------------------------
// Each transaction runs through the states idle, exec, read and check:
// it is captured at acceptance in idle, then the event is applied, the
// queue head is read from the queue memory (registered read) and the head
// check loads the result register. The sequencer runs one transaction at
// a time; a new one is taken as soon as it is back in idle, while the
// previous result may still sit in the output register. A stalled output
// holds the next transaction in its head check until the stall clears.
// Exactly one result comes out per transaction. The ring size written on
// the configuration port is clamped to 2..MAX_REQUESTERS.
module fork_pair_fifo_arbiter
    import fpfa_pkg::*;
#(
    parameter int MAX_REQUESTERS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       func,
    input  wire logic [4:0] requester_id,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            grant_valid,
    output logic [4:0]      grant_id,
    output logic            release_error,
    output logic            queue_overflow,
    output logic            bad_id,
    output logic            all_satisfied
);

    fpfa_cmd_t    cmd;
    fpfa_status_t status;

    fpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fpfa_datapath #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .func           (func),
        .requester_id   (requester_id),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .grant_valid    (grant_valid),
        .grant_id       (grant_id),
        .release_error  (release_error),
        .queue_overflow (queue_overflow),
        .bad_id         (bad_id),
        .all_satisfied  (all_satisfied)
    );

    // one transaction in flight: acceptance closes the input for a while
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_no_grant_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !grant_valid |-> grant_id == 5'd0)
        else $error("grant id set without a grant");

    a_bad_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_id |-> !queue_overflow && !release_error)
        else $error("bad id flagged together with an event outcome");

    a_flag_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(queue_overflow && release_error))
        else $error("overflow and release error in one result");

endmodule
`default_nettype wire
